// ===== hw/rtl/i2cseq_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C transfer event sequencer package
// Shared payload types, operation codes and bit positions of the event and
// error flag fields.
// ----------------------------------------------------------------------------
package i2cseq_pkg;

  localparam int unsigned BufDepthDefault = 256;
  localparam int unsigned LenW            = 9;

  // Operation codes
  localparam logic [1:0] OpWriteBuf = 2'd0;
  localparam logic [1:0] OpReadBuf  = 2'd1;
  localparam logic [1:0] OpStart    = 2'd2;
  localparam logic [1:0] OpEvent    = 2'd3;

  // Bit positions in event_flags
  localparam int unsigned EvStartSent = 0;
  localparam int unsigned EvAddr      = 1;
  localparam int unsigned EvTxEmpty   = 2;
  localparam int unsigned EvRxFull    = 3;
  localparam int unsigned EvStop      = 4;
  localparam int unsigned EvTransmit  = 5;
  localparam int unsigned EvMaster    = 6;

  // Bit positions in error_flags
  localparam int unsigned ErrAckFail = 2;

  typedef struct packed {
    logic [1:0]      operation;
    logic            buffer_select;
    logic [7:0]      index;
    logic [7:0]      value;
    logic            read_not_write;
    logic [6:0]      slave_address;
    logic [LenW-1:0] byte_count;
    logic [6:0]      event_flags;
    logic [3:0]      error_flags;
  } in_t;

  typedef struct packed {
    logic       data_out_valid;
    logic [7:0] data_out;
    logic       ack_enable;
    logic       send_start;
    logic       send_stop;
    logic       tx_done;
    logic       rx_done;
    logic [3:0] error_report;
    logic       address_nack;
    logic       master_active;
  } out_t;

endpackage

// ===== hw/rtl/i2cseq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port; the read data is registered and holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
module i2cseq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/i2c_transfer_event_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// I2C transfer event sequencer
// Turns bus controller events into data, acknowledge and start/stop requests
// for master and slave transfers, with a master and a slave byte buffer.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while in_stall_o is low
// and returns one result for each: the transaction passes the buffer RAM
// access with its registered read data, then the result register.
// Sequencing state lives in flip-flops and is updated as each transaction is
// accepted, so a bus event may directly follow a buffer write or another
// event. Buffer contents are not cleared at reset; reading a byte that was
// never written returns an unspecified value. Positions at or above BUF_DEPTH
// read as zero and ignore writes. slave_length is written through cfg_we_i
// and should only change while the block is idle.
// ----------------------------------------------------------------------------
module i2c_transfer_event_sequencer_core #(
  parameter int unsigned BUF_DEPTH = i2cseq_pkg::BufDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  i2cseq_pkg::in_t             in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output i2cseq_pkg::out_t            out_o,
  input  logic                        cfg_we_i,
  input  logic [i2cseq_pkg::LenW-1:0] cfg_wdata_i
);

  localparam int unsigned AddrW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam logic [i2cseq_pkg::LenW-1:0] BufLimit = i2cseq_pkg::LenW'(BUF_DEPTH);

  typedef enum logic [7:0] {
    PhIdle      = 8'b0000_0001,
    PhAddrSent  = 8'b0000_0010,
    PhAddrAcked = 8'b0000_0100,
    PhTxData    = 8'b0000_1000,
    PhTxLast    = 8'b0001_0000,
    PhRxData    = 8'b0010_0000,
    PhRxLast    = 8'b0100_0000,
    PhReleased  = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    i2cseq_pkg::out_t res;
    logic             use_ram;
    logic             rd_sel;
    logic             rd_oob;
  } s1_t;

  // Sequencing state
  logic [i2cseq_pkg::LenW-1:0] pos_q, pos_d;
  logic [i2cseq_pkg::LenW-1:0] mlen_q, mlen_d;
  logic [i2cseq_pkg::LenW-1:0] slen_q;
  logic [6:0]                  tgt_q, tgt_d;
  logic                        dir_q, dir_d;
  logic                        mflag_q, mflag_d;
  logic                        ack_q, ack_d;
  phase_e                      phase_q, phase_d;

  // Pipeline
  logic             s1_valid_q;
  s1_t              s1_q, s1_d;
  logic             out_valid_q;
  i2cseq_pkg::out_t out_q, out_d;
  logic             in_acc;
  logic             s1_adv;

  // Buffer access of the current transaction
  logic                        m_we, s_we, rd_en, rd_sel;
  logic [i2cseq_pkg::LenW-1:0] wpos, rpos;
  logic [7:0]                  wdata;
  logic                        m_we_g, s_we_g, m_re_g, s_re_g;
  logic [7:0]                  m_rdata, s_rdata;
  logic [7:0]                  rd_byte;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    pos_d   = pos_q;
    mlen_d  = mlen_q;
    tgt_d   = tgt_q;
    dir_d   = dir_q;
    mflag_d = mflag_q;
    ack_d   = ack_q;
    phase_d = phase_q;
    s1_d    = '0;
    m_we    = 1'b0;
    s_we    = 1'b0;
    rd_en   = 1'b0;
    rd_sel  = in_i.buffer_select;
    wpos    = {1'b0, in_i.index};
    rpos    = {1'b0, in_i.index};
    wdata   = in_i.value;

    unique case (in_i.operation)
      i2cseq_pkg::OpWriteBuf: begin
        m_we = !in_i.buffer_select;
        s_we = in_i.buffer_select;
      end
      i2cseq_pkg::OpReadBuf: begin
        rd_en = 1'b1;
      end
      i2cseq_pkg::OpStart: begin
        dir_d   = in_i.read_not_write;
        tgt_d   = in_i.slave_address;
        pos_d   = '0;
        mlen_d  = in_i.byte_count;
        mflag_d = 1'b1;
        phase_d = PhIdle;
        ack_d   = 1'b1;
        s1_d.res.send_start = 1'b1;
      end
      i2cseq_pkg::OpEvent: begin
        wpos = pos_q;
        rpos = pos_q;
        if (mflag_q) begin
          rd_sel = 1'b0;
          if (in_i.event_flags[i2cseq_pkg::EvStartSent]) begin
            s1_d.res.data_out_valid = 1'b1;
            s1_d.res.data_out       = {tgt_q, dir_q};
            phase_d                 = PhAddrSent;
          end else if (in_i.event_flags[i2cseq_pkg::EvAddr]) begin
            pos_d   = '0;
            phase_d = PhAddrAcked;
          end else if (in_i.event_flags[i2cseq_pkg::EvTransmit]) begin
            if (in_i.event_flags[i2cseq_pkg::EvTxEmpty]) begin
              s1_d.res.data_out_valid = 1'b1;
              rd_en   = 1'b1;
              pos_d   = pos_q + 1'b1;
              phase_d = PhTxData;
              if (pos_d == mlen_q) begin
                s1_d.res.send_stop = 1'b1;
                s1_d.res.tx_done   = 1'b1;
                phase_d            = PhTxLast;
              end
            end
          end else if (in_i.event_flags[i2cseq_pkg::EvRxFull]) begin
            if (pos_q < mlen_q) begin
              m_we    = 1'b1;
              phase_d = PhRxData;
            end
            if (mlen_q != '0 && pos_q == mlen_q - 1'b1) begin
              ack_d              = 1'b0;
              s1_d.res.send_stop = 1'b1;
              s1_d.res.rx_done   = 1'b1;
              phase_d            = PhRxLast;
            end else if (pos_q >= mlen_q) begin
              // Master read is over: hand the bus back and act as a slave.
              mflag_d = 1'b0;
              ack_d   = 1'b1;
              phase_d = PhReleased;
            end
            pos_d = pos_q + 1'b1;
          end
        end else begin
          rd_sel = 1'b1;
          if (in_i.event_flags[i2cseq_pkg::EvAddr]) begin
            ack_d = 1'b1;
            pos_d = '0;
          end else if (in_i.event_flags[i2cseq_pkg::EvRxFull]) begin
            if (pos_q < slen_q) begin
              s_we  = 1'b1;
              pos_d = pos_q + 1'b1;
            end
            ack_d = 1'b1;
          end else if (in_i.event_flags[i2cseq_pkg::EvTxEmpty]) begin
            s1_d.res.data_out_valid = 1'b1;
            // Beyond the configured length the slave sends zeros.
            if (pos_q < slen_q) begin
              rd_en = 1'b1;
              pos_d = pos_q + 1'b1;
            end
          end
        end

        if (in_i.error_flags != '0) begin
          s1_d.res.error_report = in_i.error_flags;
          s1_d.res.address_nack = in_i.error_flags[i2cseq_pkg::ErrAckFail] &&
                                  (phase_d == PhAddrSent);
          if (in_i.event_flags[i2cseq_pkg::EvMaster]) begin
            s1_d.res.send_stop = 1'b1;
          end
        end
        // A detected stop clears the acknowledge enable and the start and stop requests.
        if (in_i.event_flags[i2cseq_pkg::EvStop]) begin
          ack_d               = 1'b0;
          s1_d.res.send_start = 1'b0;
          s1_d.res.send_stop  = 1'b0;
        end
      end
      default: begin
      end
    endcase

    s1_d.res.ack_enable    = ack_d;
    s1_d.res.master_active = mflag_d;
    s1_d.use_ram           = rd_en;
    s1_d.rd_sel            = rd_sel;
    s1_d.rd_oob            = (rpos >= BufLimit);
  end

  assign m_we_g = in_acc && m_we && (wpos < BufLimit);
  assign s_we_g = in_acc && s_we && (wpos < BufLimit);
  assign m_re_g = in_acc && rd_en && !rd_sel;
  assign s_re_g = in_acc && rd_en && rd_sel;

  i2cseq_ram #(
    .Width (8),
    .Depth (BUF_DEPTH)
  ) u_master_ram (
    .clk_i   (clk_i),
    .we_i    (m_we_g),
    .waddr_i (wpos[AddrW-1:0]),
    .wdata_i (wdata),
    .re_i    (m_re_g),
    .raddr_i (rpos[AddrW-1:0]),
    .rdata_o (m_rdata)
  );

  i2cseq_ram #(
    .Width (8),
    .Depth (BUF_DEPTH)
  ) u_slave_ram (
    .clk_i   (clk_i),
    .we_i    (s_we_g),
    .waddr_i (wpos[AddrW-1:0]),
    .wdata_i (wdata),
    .re_i    (s_re_g),
    .raddr_i (rpos[AddrW-1:0]),
    .rdata_o (s_rdata)
  );

  assign rd_byte = s1_q.rd_oob ? 8'h00 : (s1_q.rd_sel ? s_rdata : m_rdata);

  always_comb begin
    out_d = s1_q.res;
    if (s1_q.use_ram) begin
      out_d.data_out = rd_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      mlen_q      <= '0;
      slen_q      <= '0;
      tgt_q       <= '0;
      dir_q       <= 1'b0;
      mflag_q     <= 1'b0;
      ack_q       <= 1'b0;
      phase_q     <= PhIdle;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        slen_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        pos_q   <= pos_d;
        mlen_q  <= mlen_d;
        tgt_q   <= tgt_d;
        dir_q   <= dir_d;
        mflag_q <= mflag_d;
        ack_q   <= ack_d;
        phase_q <= phase_d;
      end
      if (in_acc || s1_adv) begin
        s1_valid_q <= in_acc;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== hw/rtl/i2cseq_checker.sv =====
// ----------------------------------------------------------------------------
// I2C transfer event sequencer checker
// Port-level checks on the result stream, attached to the core by bind.
// ----------------------------------------------------------------------------
module i2cseq_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input i2cseq_pkg::out_t out_o
);

  // A stalled result stays on the port unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed or was dropped");

  // A start request always arms master mode with the acknowledge enabled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.send_start |-> out_o.ack_enable && out_o.master_active)
    else $error("start request without master mode and acknowledge");

  // The last received master byte is answered without acknowledge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.rx_done |-> !out_o.ack_enable && out_o.master_active &&
                                     !out_o.tx_done)
    else $error("master read completion with acknowledge or wrong mode");

  // An address not acknowledged is only seen in master mode with ack failure.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.address_nack |->
      out_o.master_active && out_o.error_report[i2cseq_pkg::ErrAckFail])
    else $error("address nack outside master mode or without ack failure");

endmodule

bind i2c_transfer_event_sequencer_core i2cseq_checker u_i2cseq_checker (.*);
